// ===== rtl/rbst_pkg.sv =====
// Shared types and constants for the ray versus box slab test.
package rbst_pkg;

   localparam int CoordWidth    = 32;
   localparam int DiffWidth     = CoordWidth + 1;
   localparam int DistWidth     = 64;
   localparam int Axes          = 3;
   localparam int CsrIndexWidth = 3;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DiffWidth-1:0]  diff_type;
   typedef logic signed [DistWidth-1:0]  dist_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_index_type;

endpackage

// ===== rtl/rbst_slab_dist.sv =====
// One axis of the slab test: corner offsets, slab distances and their ordering.
module rbst_slab_dist
   import rbst_pkg::*;
(
   input  logic      clock,
   input  logic      enable,
   input  coord_type box_min,
   input  coord_type box_max,
   input  coord_type origin,
   input  coord_type inv_dir,
   output dist_type  lo,
   output dist_type  hi
);

   diff_type  diff_min_ff, diff_min_in;
   diff_type  diff_max_ff, diff_max_in;
   coord_type inv_ff;

   logic signed [DistWidth:0] prod_min_full, prod_max_full;
   dist_type t1_ff, t1_in;
   dist_type t2_ff, t2_in;

   dist_type lo_ff, lo_in;
   dist_type hi_ff, hi_in;

   // stage 1: exact 33-bit offsets
   assign diff_min_in = diff_type'(box_min) - diff_type'(origin);
   assign diff_max_in = diff_type'(box_max) - diff_type'(origin);

   // stage 2: exact products, magnitude fits 64 bits signed
   assign prod_min_full = (DistWidth+1)'(diff_min_ff) * (DistWidth+1)'(inv_ff);
   assign prod_max_full = (DistWidth+1)'(diff_max_ff) * (DistWidth+1)'(inv_ff);
   assign t1_in = prod_min_full[DistWidth-1:0];
   assign t2_in = prod_max_full[DistWidth-1:0];

   // stage 3: order the pair
   always_comb begin
      if (t1_ff < t2_ff) begin
         lo_in = t1_ff;
         hi_in = t2_ff;
      end else begin
         lo_in = t2_ff;
         hi_in = t1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_min_ff <= diff_min_in;
         diff_max_ff <= diff_max_in;
         inv_ff      <= inv_dir;
         t1_ff       <= t1_in;
         t2_ff       <= t2_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule

// ===== rtl/rbst_merge.sv =====
// Entry/exit reduction over the three axes and the final hit decision.
module rbst_merge
   import rbst_pkg::*;
(
   input  logic     clock,
   input  logic     enable,
   input  dist_type lo [Axes],
   input  dist_type hi [Axes],
   output logic     hit
);

   dist_type entry01_ff, entry01_in;
   dist_type exit01_ff, exit01_in;
   dist_type lo2_ff, hi2_ff;
   dist_type entry_ff, entry_in;
   dist_type exit_ff, exit_in;
   dist_type entry_clamp;
   logic     hit_ff, hit_in;

   // stage 4: x against y
   assign entry01_in = (lo[1] > lo[0]) ? lo[1] : lo[0];
   assign exit01_in  = (hi[1] < hi[0]) ? hi[1] : hi[0];

   // stage 5: fold in z
   assign entry_in = (lo2_ff > entry01_ff) ? lo2_ff : entry01_ff;
   assign exit_in  = (hi2_ff < exit01_ff) ? hi2_ff : exit01_ff;

   // stage 6: clamp entry to the origin, strict compare
   assign entry_clamp = entry_ff[DistWidth-1] ? '0 : entry_ff;
   assign hit_in      = exit_ff > entry_clamp;

   always_ff @(posedge clock) begin
      if (enable) begin
         entry01_ff <= entry01_in;
         exit01_ff  <= exit01_in;
         lo2_ff     <= lo[2];
         hi2_ff     <= hi[2];
         entry_ff   <= entry_in;
         exit_ff    <= exit_in;
         hit_ff     <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ===== rtl/ray_box_slab_test.sv =====
// An accepted request passes offset, product, ordering, x/y, z and hit registers.
// Throughput: one ray per cycle; the whole pipeline holds while a response waits
// under rsp_stall, so the output register is the only place a result can wait.
// Reset (synchronous, active high) clears all six box registers to zero and
// empties the pipeline; request and CSR transfers are refused during reset.
module ray_box_slab_test
   import rbst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   // ray requests
   input  logic                     req_valid,
   output logic                     req_stall,
   input  coord_type                req_origin_x,
   input  coord_type                req_origin_y,
   input  coord_type                req_origin_z,
   input  coord_type                req_inv_dir_x,
   input  coord_type                req_inv_dir_y,
   input  coord_type                req_inv_dir_z,

   // hit responses
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,

   // box corner registers
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  coord_type                csr_wdata
);

   // stages: offsets, products, ordering, x/y merge, z merge, hit
   localparam int StageCount = 6;

   coord_type box_min_ff [Axes];
   coord_type box_max_ff [Axes];

   logic [StageCount-1:0] valid_ff, valid_in;
   logic                  pipe_en;
   logic                  req_xfer;

   coord_type origin  [Axes];
   coord_type inv_dir [Axes];
   dist_type  slab_lo [Axes];
   dist_type  slab_hi [Axes];

   // Global advance: every stage moves unless a finished response sits stalled.
   // Bubbles travel too, so a stall never drops or doubles an item.
   assign pipe_en   = !(valid_ff[StageCount-1] && rsp_stall);
   assign req_stall = reset || !pipe_en;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = !reset;

   assign valid_in = {valid_ff[StageCount-2:0], req_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= valid_in;
      end
   end

   // CSR writes; indexes past the max corner are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Axes; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_wdata;
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_wdata;
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_wdata;
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_wdata;
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_wdata;
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign origin[0]  = req_origin_x;
   assign origin[1]  = req_origin_y;
   assign origin[2]  = req_origin_z;
   assign inv_dir[0] = req_inv_dir_x;
   assign inv_dir[1] = req_inv_dir_y;
   assign inv_dir[2] = req_inv_dir_z;

   // Stages 1-3, one lane per axis
   for (genvar a = 0; a < Axes; a++) begin : g_axis
      rbst_slab_dist u_slab (
         .clock   (clock),
         .enable  (pipe_en),
         .box_min (box_min_ff[a]),
         .box_max (box_max_ff[a]),
         .origin  (origin[a]),
         .inv_dir (inv_dir[a]),
         .lo      (slab_lo[a]),
         .hi      (slab_hi[a])
      );
   end

   // Stages 4-6, result lands in the output register
   rbst_merge u_merge (
      .clock  (clock),
      .enable (pipe_en),
      .lo     (slab_lo),
      .hi     (slab_hi),
      .hit    (rsp_hit)
   );

   assign rsp_valid = valid_ff[StageCount-1];

`ifndef ASSERT_OFF
   // a waiting response blocks new request transfers
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !req_xfer)
      else $error("request taken while response stalled");

   // valid bits shift by one stage when the pipe advances
   a_valid_shift: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $past(pipe_en)) |->
         (valid_ff == {$past(valid_ff[StageCount-2:0]), $past(req_xfer)}))
      else $error("valid chain lost or duplicated an item");

   // valid bits hold while the pipe is frozen
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $past(!pipe_en)) |-> $stable(valid_ff))
      else $error("valid chain moved during stall");
`endif

endmodule

// ===== test/ray_box_slab_test_tb.sv =====
// Self-checking testbench for the ray versus box slab test block.
module ray_box_slab_test_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rbst_pkg::*;

   localparam int        One      = 65536;           // 1.0 in Q16.16
   localparam coord_type CoordMax = 32'sh7FFF_FFFF;
   localparam coord_type CoordMin = 32'sh8000_0000;
   localparam int        IdlePct  = 14;

   typedef struct {
      coord_type origin[Axes];
      coord_type inv_dir[Axes];
   } ray_item;

   typedef struct {
      coord_type lo[Axes];
      coord_type hi[Axes];
   } box_corners;

   // Scoreboard: shadow copy of the box corners, hit predictor and the queue of
   // hits still owed by the block.
   class slab_hit_board;
      coord_type corner_lo[Axes];
      coord_type corner_hi[Axes];
      bit        pending_hits[$];
      int        errors;

      function new();
         foreach (corner_lo[a]) begin
            corner_lo[a] = '0;
            corner_hi[a] = '0;
         end
         errors = 0;
      endfunction

      // Indices past the last corner register are dropped by the block.
      function void set_corner(logic [CsrIndexWidth-1:0] index, coord_type value);
         if (index <= CSR_BOX_MIN_Z) begin
            corner_lo[index] = value;
         end else if (index <= CSR_BOX_MAX_Z) begin
            corner_hi[index - CSR_BOX_MAX_X] = value;
         end
      endfunction

      // Exact slab test: 33-bit differences, 64-bit products, no rounding.
      function bit predict_hit(ray_item r);
         diff_type d_lo, d_hi;
         dist_type t1, t2, near_d, far_d, entry_d, exit_d;
         for (int a = 0; a < Axes; a++) begin
            d_lo = corner_lo[a] - r.origin[a];
            d_hi = corner_hi[a] - r.origin[a];
            t1 = d_lo * r.inv_dir[a];
            t2 = d_hi * r.inv_dir[a];
            near_d = (t1 < t2) ? t1 : t2;
            far_d  = (t1 < t2) ? t2 : t1;
            if (a == 0) begin
               entry_d = near_d;
               exit_d  = far_d;
            end else begin
               if (near_d > entry_d) entry_d = near_d;
               if (far_d < exit_d) exit_d = far_d;
            end
         end
         if (entry_d < 0) entry_d = 0;
         return exit_d > entry_d;
      endfunction

      function void note_ray(ray_item r);
         pending_hits.push_back(predict_hit(r));
      endfunction

      function void check_hit(logic got);
         bit want;
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual hit=%b", $time, got);
            errors++;
         end else begin
            want = pending_hits.pop_front();
            if (got !== want) begin
               $display("%0t: hit mismatch, expected %b, actual %b", $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid     = 1'b0;
   logic      req_stall;
   coord_type req_origin_x  = '0;
   coord_type req_origin_y  = '0;
   coord_type req_origin_z  = '0;
   coord_type req_inv_dir_x = '0;
   coord_type req_inv_dir_y = '0;
   coord_type req_inv_dir_z = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   coord_type                csr_wdata = '0;

   // When set, neither side idles: gives a long back-to-back stretch.
   bit calm = 1'b0;

   slab_hit_board board = new();

   ray_box_slab_test dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_origin_x  (req_origin_x),
      .req_origin_y  (req_origin_y),
      .req_origin_z  (req_origin_z),
      .req_inv_dir_x (req_inv_dir_x),
      .req_inv_dir_y (req_inv_dir_y),
      .req_inv_dir_z (req_inv_dir_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #2 clock = ~clock;

   // Hard stop in case a transfer never completes.
   initial begin
      #200us;
      $display("status: fail");
      $finish;
   end

   // Response side back-pressure, roughly one cycle in seven.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
   end

   // A response transfer happens at any edge with valid high and stall low.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         board.check_hit(rsp_hit);
      end
   end

   // Small signed value, about +/-32.0.
   function automatic coord_type small_coord();
      return $urandom_range(0, 1 << 22) - (1 << 21);
   endfunction

   // Mix of boundary values, small values and raw 32-bit patterns.
   function automatic coord_type any_coord();
      coord_type boundary[5] = '{CoordMin, CoordMax, 0, -1, 1};
      case ($urandom_range(0, 3))
         0: return boundary[$urandom_range(0, 4)];
         1: return small_coord();
         default: return $urandom;
      endcase
   endfunction

   // Q16.16 reciprocal of a direction, saturated; zero gives an infinite one.
   function automatic coord_type q16_reciprocal(longint d);
      longint q;
      if (d == 0) return $urandom_range(0, 1) ? CoordMax : CoordMin;
      q = (longint'(1) <<< 32) / d;
      if (q > longint'(CoordMax)) return CoordMax;
      if (q < longint'(CoordMin)) return CoordMin;
      return coord_type'(q);
   endfunction

   function automatic ray_item mk_ray(int ox, int oy, int oz, int ix, int iy, int iz);
      ray_item r;
      r.origin  = '{ox, oy, oz};
      r.inv_dir = '{ix, iy, iz};
      return r;
   endfunction

   // Most rays are aimed at a point inside the current box, so hits are common;
   // rest are noise, turned away, flat or noisy on one axis, or start on a plane.
   function automatic ray_item random_ray();
      ray_item r;
      int      mode, a;
      longint  lo, hi, span, target, orig;
      mode = $urandom_range(0, 99);
      for (a = 0; a < Axes; a++) begin
         lo = board.corner_lo[a];
         hi = board.corner_hi[a];
         if (lo > hi) begin
            span = lo;
            lo = hi;
            hi = span;
         end
         span   = hi - lo + 1;
         target = lo + longint'({$urandom, $urandom} >> 1) % span;
         orig   = target + ($urandom_range(0, 1) ? 1 : -1) *
                  longint'($urandom_range(0, 1 << 22));
         if (orig > longint'(CoordMax)) orig = CoordMax;
         if (orig < longint'(CoordMin)) orig = CoordMin;
         r.origin[a]  = coord_type'(orig);
         r.inv_dir[a] = q16_reciprocal(target - orig);
         if (mode < 25) begin
            r.origin[a]  = any_coord();
            r.inv_dir[a] = any_coord();
         end
      end
      a = $urandom_range(0, Axes - 1);
      if (mode >= 25 && mode < 35) begin
         r.inv_dir[a] = -r.inv_dir[a];
      end else if (mode >= 35 && mode < 45) begin
         r.inv_dir[a] = '0;
      end else if (mode >= 45 && mode < 55) begin
         r.origin[a]  = $urandom_range(0, 1) ? board.corner_lo[a] : board.corner_hi[a];
         r.inv_dir[a] = $urandom_range(0, 1) ? CoordMax : CoordMin;
      end else if (mode >= 55 && mode < 65) begin
         if ($urandom_range(0, 1)) r.origin[a] = any_coord();
         else r.inv_dir[a] = any_coord();
      end
      return r;
   endfunction

   // Box settings per phase: full range, full range inverted, small any order,
   // small, raw patterns, one flat axis, then small again.
   function automatic box_corners pick_box(int phase);
      box_corners b;
      coord_type  p, q;
      for (int a = 0; a < Axes; a++) begin
         p = small_coord();
         q = small_coord();
         case (phase)
            0: begin
               b.lo[a] = CoordMin;
               b.hi[a] = CoordMax;
            end
            1: begin
               b.lo[a] = CoordMax;
               b.hi[a] = CoordMin;
            end
            2: begin
               b.lo[a] = p;
               b.hi[a] = q;
            end
            4: begin
               b.lo[a] = $urandom;
               b.hi[a] = $urandom;
            end
            default: begin
               if (phase == 5 && a == 0) q = p;
               b.lo[a] = (p < q) ? p : q;
               b.hi[a] = (p < q) ? q : p;
            end
         endcase
      end
      return b;
   endfunction

   // Request side idle cycles; valid only drops between transfers.
   task automatic ray_gap();
      if (!calm) begin
         while ($urandom_range(0, 99) < IdlePct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Present one ray and hold it until the transfer completes. Valid is left
   // high so that back-to-back rays need no extra assignment.
   task automatic send_ray(ray_item r);
      req_valid     <= 1'b1;
      req_origin_x  <= r.origin[0];
      req_origin_y  <= r.origin[1];
      req_origin_z  <= r.origin[2];
      req_inv_dir_x <= r.inv_dir[0];
      req_inv_dir_y <= r.inv_dir[1];
      req_inv_dir_z <= r.inv_dir[2];
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_ray(r);
   endtask

   task automatic random_rays(int count);
      repeat (count) begin
         ray_gap();
         send_ray(random_ray());
      end
   endtask

   // Every ray gives exactly one response, so an empty queue means the
   // pipeline is idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_hits.size() != 0) @(posedge clock);
   endtask

   // Write all six corners, then the unused indices, which must be dropped.
   task automatic load_box(box_corners b);
      coord_type v;
      for (int i = CSR_BOX_MIN_X; i < (1 << CsrIndexWidth); i++) begin
         if (i <= CSR_BOX_MIN_Z) v = b.lo[i];
         else if (i <= CSR_BOX_MAX_Z) v = b.hi[i - CSR_BOX_MAX_X];
         else v = $urandom;
         csr_valid <= 1'b1;
         csr_index <= i[CsrIndexWidth-1:0];
         csr_wdata <= v;
         do @(posedge clock); while (csr_ready !== 1'b1);
         board.set_corner(i[CsrIndexWidth-1:0], v);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      box_corners unit_box;
      ray_item    directed[$];

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Corners straight out of reset: a flat box at the origin, never hit.
      random_rays(10);
      drain();

      // Unit box, +/-1.0 on every axis.
      foreach (unit_box.lo[a]) begin
         unit_box.lo[a] = -One;
         unit_box.hi[a] = One;
      end
      load_box(unit_box);

      // inside the box, all axes moving
      directed.push_back(mk_ray(0, 0, 0, One, One, One));
      // zero inverse on two axes: those slabs collapse to zero
      directed.push_back(mk_ray(-2 * One, 0, 0, One, 0, 0));
      // infinite inverse of either sign with the origin inside the slab
      directed.push_back(mk_ray(-2 * One, 0, 0, One, CoordMax, CoordMin));
      // origin on the slab plane with an infinite inverse
      directed.push_back(mk_ray(-One, 0, 0, CoordMax, One, One));
      directed.push_back(mk_ray(0, One, 0, One, CoordMin, One));
      // box behind the origin
      directed.push_back(mk_ray(2 * One, 0, 0, One, One, One));
      // pointing away
      directed.push_back(mk_ray(-2 * One, 0, 0, -One, One, One));
      // grazes an edge: exit equals entry
      directed.push_back(mk_ray(-2 * One, 2 * One, -4 * One, One, -One, One));
      // clean hit from outside
      directed.push_back(mk_ray(-3 * One, -3 * One, -3 * One, One, One, One));
      // field extremes
      directed.push_back(mk_ray(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
      directed.push_back(mk_ray(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin));
      directed.push_back(mk_ray(CoordMin, CoordMax, CoordMin, CoordMin, CoordMax, CoordMin));
      directed.push_back(mk_ray(CoordMax, CoordMin, CoordMax, CoordMax, CoordMin, CoordMax));
      directed.push_back(mk_ray(0, 0, 0, 0, 0, 0));
      directed.push_back(mk_ray(-1, -1, -1, -1, -1, -1));
      directed.push_back(mk_ray(1, 1, 1, 1, 1, 1));
      directed.push_back(mk_ray(0, 0, 0, CoordMax, CoordMin, CoordMax));
      directed.push_back(mk_ray(-One, -One, -One, CoordMax, CoordMax, CoordMax));
      foreach (directed[k]) begin
         ray_gap();
         send_ray(directed[k]);
      end

      // Random phases; corners only change once the pipeline is empty.
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         load_box(pick_box(phase));
         calm = (phase == 3);
         random_rays(130);
         calm = 1'b0;
      end

      drain();
      repeat (10) @(posedge clock);   // catch any stray response
      if (board.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
